### rtl/core/threshold_counter_bank_core_macros.svh
// Assertion macros for the threshold counter bank core.
// No dependencies; included by the modules that carry assertions.
`ifndef THRESHOLD_COUNTER_BANK_CORE_MACROS_SVH
`define THRESHOLD_COUNTER_BANK_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TCB_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TCB_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tcb_pkg.sv
// Shared types and constants for the threshold counter bank core.
// No dependencies; imported by every module of the block.
package tcb_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 16;
  localparam logic [31:0] ALL_ENTRIES     = 32'h0000_00ff;
  localparam logic [31:0] COUNT_MAX       = 32'hffff_ffff;

  // Request codes; code 3 is unused
  typedef enum logic [1:0] {
    REQ_INCREMENT = 2'd0,
    REQ_RESET     = 2'd1,
    REQ_SET_PARAM = 2'd2
  } req_type_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] counter_index;
    logic [31:0] new_threshold;
    logic [7:0]  new_arm;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        anomaly_raised;
    logic [7:0]  anomaly_index;
    logic [31:0] count_value;
  } rsp_t;

  // One word of the entry RAM
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] threshold;
    logic        armed;
  } entry_t;

  // Update decision handed from the update logic to the control
  typedef struct packed {
    logic   wr_en;
    logic   clr_all;
    entry_t wr_entry;
    rsp_t   rsp;
  } upd_t;

endpackage

### rtl/core/tcb_entry_ram.sv
// Single-port-write, registered-read RAM holding counter, threshold and arm flag.
// Depends on tcb_pkg for the entry word type.
module tcb_entry_ram #(
  parameter int unsigned DEPTH = tcb_pkg::NUM_ENTRIES_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  tcb_pkg::entry_t                         wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output tcb_pkg::entry_t                         rdata_o
);
  import tcb_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tcb_update.sv
// Read-modify-write logic: next entry word and result for one request.
// Depends on tcb_pkg for request, entry and result types.
module tcb_update #(
  parameter int unsigned NUM_ENTRIES = tcb_pkg::NUM_ENTRIES_DEF
) (
  input  tcb_pkg::req_t   req_i,
  input  tcb_pkg::entry_t cur_i,
  output tcb_pkg::upd_t   upd_o
);
  import tcb_pkg::*;

  logic        in_range;
  logic [31:0] inc_count;
  logic        fire;
  logic        arm_bad;

  assign in_range  = req_i.counter_index < 32'(NUM_ENTRIES);
  // Plain 32-bit add wraps all ones to zero
  assign inc_count = cur_i.count + 32'd1;
  assign fire      = cur_i.armed && (inc_count >= cur_i.threshold);
  assign arm_bad   = req_i.new_arm > 8'd1;

  // Request decode
  always_comb begin
    upd_o                 = '0;
    upd_o.wr_entry        = cur_i;
    upd_o.rsp.status      = 1'b1;
    case (req_i.req_type)
      REQ_INCREMENT: begin
        if (in_range) begin
          upd_o.wr_en                = 1'b1;
          upd_o.wr_entry.count       = inc_count;
          upd_o.wr_entry.armed       = cur_i.armed & ~fire;
          upd_o.rsp.status           = 1'b0;
          upd_o.rsp.anomaly_raised   = fire;
          upd_o.rsp.anomaly_index    = fire ? req_i.counter_index[7:0] : 8'd0;
          upd_o.rsp.count_value      = inc_count;
        end
      end
      REQ_RESET: begin
        if (in_range) begin
          upd_o.wr_en          = 1'b1;
          upd_o.wr_entry.count = '0;
          upd_o.rsp.status     = 1'b0;
        end else if (req_i.counter_index == ALL_ENTRIES) begin
          upd_o.clr_all    = 1'b1;
          upd_o.rsp.status = 1'b0;
        end
      end
      REQ_SET_PARAM: begin
        if (in_range) begin
          upd_o.wr_en              = 1'b1;
          upd_o.wr_entry.threshold = req_i.new_threshold;
          upd_o.wr_entry.armed     = arm_bad ? 1'b0 : req_i.new_arm[0];
          upd_o.rsp.status         = arm_bad;
          upd_o.rsp.count_value    = cur_i.count;
        end
      end
      default: begin
        upd_o.rsp.status = 1'b1;
      end
    endcase
  end

endmodule

### rtl/core/threshold_counter_bank_core.sv
// Top level of the threshold counter bank: control, valid bits, RAM and update.
// Depends on tcb_pkg, tcb_entry_ram, tcb_update and the assertion macro header.
//
//   Channel   Handshake          Payload
//   request   start / busy       req_i  (tcb_pkg::req_t)
//   result    done_o strobe      rsp_o  (tcb_pkg::rsp_t)
//
// Each request reads the entry RAM, then updates, writes back and registers the
// result. busy is high for the update cycle, which keeps the next read behind the
// write-back. done_o pulses for one cycle and cannot be stalled. Reset and
// clear-all clear all the per-entry valid bits together; an entry whose valid
// bit is low reads as all zero, so no clearing pass.
`include "threshold_counter_bank_core_macros.svh"

module threshold_counter_bank_core #(
  parameter int unsigned NUM_ENTRIES = tcb_pkg::NUM_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  tcb_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output tcb_pkg::rsp_t rsp_o
);
  import tcb_pkg::*;

  localparam int unsigned AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  state_e                 state_q;
  logic                   done_q;
  rsp_t                   rsp_q;
  req_t                   req_q;
  logic                   ent_vld_q;
  logic [NUM_ENTRIES-1:0] vld_q;

  logic                   accept;
  logic                   rd_in_range;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  entry_t                 ram_rdata;
  entry_t                 cur_entry;
  upd_t                   upd;
  logic                   wr_go;
  logic                   clr_go;

  assign accept      = start && !busy;
  assign busy        = (state_q == ST_UPDATE);
  assign rd_in_range = req_i.counter_index < 32'(NUM_ENTRIES);
  assign rd_addr     = rd_in_range ? req_i.counter_index[AW-1:0] : '0;
  assign wr_addr     = req_q.counter_index[AW-1:0];
  assign wr_go       = busy && upd.wr_en;
  assign clr_go      = busy && upd.clr_all;

  // Entries never written since the last clear read as zero
  assign cur_entry = ent_vld_q ? ram_rdata : '0;

  tcb_entry_ram #(
    .DEPTH(NUM_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_go),
    .waddr_i(wr_addr),
    .wdata_i(upd.wr_entry),
    .re_i   (accept),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  tcb_update #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_update (
    .req_i(req_q),
    .cur_i(cur_entry),
    .upd_o(upd)
  );

  // Control state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
          rsp_q   <= upd.rsp;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Request capture and valid bit of the addressed entry
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= req_i;
      ent_vld_q <= vld_q[rd_addr];
    end
  end

  // Per-entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_go) begin
      vld_q <= '0;
    end else if (wr_go) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `TCB_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, accept, busy, "accepted request did not hold busy")
  `TCB_ASSERT_NXT(a_update_done, clk_i, rst_ni, busy, done_o, "update cycle gave no result")
  `TCB_ASSERT_NXT(a_single_done, clk_i, rst_ni, done_o, !done_o, "result strobe repeated")
  `TCB_ASSERT_IMP(a_anom_status, clk_i, rst_ni, done_o && rsp_o.anomaly_raised, !rsp_o.status, "anomaly with failing status")
  `TCB_ASSERT_NXT(a_clear_all, clk_i, rst_ni, clr_go, vld_q == '0, "clear-all left valid entries")

endmodule

### verif/threshold_counter_bank_checker.sv
// Result checker for the threshold counter bank: tracks the counter bank state,
// predicts the result of every accepted request and compares done_o transfers.
// Depends on tcb_pkg for the request and result types and the request codes.
module threshold_counter_bank_checker #(
  parameter int unsigned N_ENTRIES = tcb_pkg::NUM_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  tcb_pkg::req_t req_i,
  input  logic          done_o,
  input  tcb_pkg::rsp_t rsp_o,
  output int            errors_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcb_pkg::*;

  // Shadow copy of the bank
  logic [31:0] shadow_counts [N_ENTRIES];
  logic [31:0] shadow_thresholds [N_ENTRIES];
  logic        shadow_armed [N_ENTRIES];

  rsp_t awaited_results [$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic void clear_bank();
    for (int i = 0; i < N_ENTRIES; i++) begin
      shadow_counts[i]     = '0;
      shadow_thresholds[i] = '0;
      shadow_armed[i]      = 1'b0;
    end
  endfunction

  // Applies one request to the shadow bank and returns the result it gives
  function automatic rsp_t bank_update(input req_t r);
    rsp_t        res;
    logic        in_range;
    int unsigned e;
    res        = '0;
    res.status = 1'b1;
    in_range   = r.counter_index < N_ENTRIES;
    e          = in_range ? r.counter_index : 0;
    case (r.req_type)
      REQ_INCREMENT: begin
        if (in_range) begin
          // all ones wraps to zero
          shadow_counts[e] = shadow_counts[e] + 32'd1;
          if (shadow_counts[e] >= shadow_thresholds[e] && shadow_armed[e]) begin
            res.anomaly_raised = 1'b1;
            res.anomaly_index  = 8'(e);
            shadow_armed[e]    = 1'b0;
          end
          res.status      = 1'b0;
          res.count_value = shadow_counts[e];
        end
      end
      REQ_RESET: begin
        if (in_range) begin
          shadow_counts[e] = '0;
          res.status       = 1'b0;
        end else if (r.counter_index == ALL_ENTRIES) begin
          clear_bank();
          res.status = 1'b0;
        end
      end
      REQ_SET_PARAM: begin
        if (in_range) begin
          shadow_thresholds[e] = r.new_threshold;
          // illegal arm byte still writes the threshold but disarms
          if (r.new_arm > 8'd1) begin
            shadow_armed[e] = 1'b0;
          end else begin
            shadow_armed[e] = r.new_arm[0];
            res.status      = 1'b0;
          end
          res.count_value = shadow_counts[e];
        end
      end
      default: begin
        // unused code: status only
      end
    endcase
    return res;
  endfunction

  // Compare result transfers first, then record the request transfer
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      clear_bank();
      awaited_results.delete();
      pending_o = 0;
    end else begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transfer: %p", rsp_o);
          errors_o++;
        end else begin
          exp_rsp = awaited_results.pop_front();
          if (rsp_o.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_o.status);
            errors_o++;
          end
          if (rsp_o.anomaly_raised !== exp_rsp.anomaly_raised) begin
            $error("anomaly_raised: expected %0d, actual %0d",
                   exp_rsp.anomaly_raised, rsp_o.anomaly_raised);
            errors_o++;
          end
          if (rsp_o.anomaly_index !== exp_rsp.anomaly_index) begin
            $error("anomaly_index: expected %0d, actual %0d",
                   exp_rsp.anomaly_index, rsp_o.anomaly_index);
            errors_o++;
          end
          if (rsp_o.count_value !== exp_rsp.count_value) begin
            $error("count_value: expected %h, actual %h",
                   exp_rsp.count_value, rsp_o.count_value);
            errors_o++;
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(bank_update(req_i));
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

### verif/threshold_counter_bank_core_tb.sv
// Testbench top for the threshold counter bank: clock, reset, request stimulus
// and the verdict. Depends on tcb_pkg, threshold_counter_bank_core and
// threshold_counter_bank_checker.
module threshold_counter_bank_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcb_pkg::*;

  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic done_o;
  req_t req_i;
  rsp_t rsp_o;

  int          errors;
  int          pending;
  int unsigned cycles = 0;

  threshold_counter_bank_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  threshold_counter_bank_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic req_t make_req(input logic [1:0] kind, input logic [31:0] idx,
                                    input logic [31:0] thr, input logic [7:0] arm);
    req_t r;
    r.req_type      = kind;
    r.counter_index = idx;
    r.new_threshold = thr;
    r.new_arm       = arm;
    return r;
  endfunction

  // Mostly legal traffic with small thresholds so alarms fire; the rest is noise
  function automatic req_t random_request();
    req_t        r;
    int unsigned roll;
    r    = make_req(REQ_INCREMENT, $urandom_range(0, NUM_ENTRIES_DEF - 1), $urandom,
                    8'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      r.req_type = REQ_INCREMENT;
    end else if (roll < 65) begin
      r.req_type      = REQ_SET_PARAM;
      r.new_threshold = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 24);
      r.new_arm       = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
    end else if (roll < 75) begin
      r.req_type = REQ_RESET;
    end else if (roll < 78) begin
      r.req_type      = REQ_RESET;
      r.counter_index = ALL_ENTRIES;
    end else if (roll < 90) begin
      r.req_type      = 2'($urandom_range(0, 2));
      r.counter_index = $urandom_range(0, 1) ? $urandom
                                             : $urandom_range(NUM_ENTRIES_DEF, 300);
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  // One request transfer after an idle gap; returns on the accepting edge
  task automatic send_request(input req_t r, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
  endtask

  // Hold off until every outstanding result has come back; the first negedge
  // lets the checker record a transfer taken at the current edge
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    bit burst;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: alarm at threshold, one-shot disarm
    send_request(make_req(REQ_SET_PARAM, 0, 32'd3, 8'd1), 0);
    send_request(make_req(REQ_INCREMENT, 0, '0, '0), 0);
    send_request(make_req(REQ_INCREMENT, 0, '1, 8'hff), $urandom_range(0, 4));
    send_request(make_req(REQ_INCREMENT, 0, '0, '0), 0);
    send_request(make_req(REQ_INCREMENT, 0, '0, '0), 1);
    // zero threshold fires on the first increment, top entry
    send_request(make_req(REQ_SET_PARAM, NUM_ENTRIES_DEF - 1, '0, 8'd1), 0);
    send_request(make_req(REQ_INCREMENT, NUM_ENTRIES_DEF - 1, '0, '0), 2);
    // max threshold never fires; disarm with arm byte 0
    send_request(make_req(REQ_SET_PARAM, 3, '1, 8'd1), 0);
    send_request(make_req(REQ_INCREMENT, 3, '0, '0), 0);
    send_request(make_req(REQ_SET_PARAM, 3, 32'd0, 8'd0), 3);
    send_request(make_req(REQ_INCREMENT, 3, '0, '0), 0);
    // illegal arm bytes still write the threshold
    send_request(make_req(REQ_SET_PARAM, 5, 32'd1, 8'd2), 0);
    send_request(make_req(REQ_INCREMENT, 5, '0, '0), 0);
    send_request(make_req(REQ_SET_PARAM, 5, '1, 8'hff), 4);
    send_request(make_req(REQ_SET_PARAM, 6, 32'h8000_0000, 8'h80), 0);
    // out-of-range indexes for every request
    send_request(make_req(REQ_INCREMENT, NUM_ENTRIES_DEF, '0, '0), 0);
    send_request(make_req(REQ_INCREMENT, ALL_ENTRIES, '0, '0), 0);
    send_request(make_req(REQ_SET_PARAM, '1, '1, 8'd1), 1);
    send_request(make_req(REQ_RESET, 32'h0000_0100, '0, '0), 0);
    send_request(make_req(REQ_RESET, '1, '0, '0), 0);
    // single reset, then reset of all entries
    send_request(make_req(REQ_RESET, 0, '0, '0), 0);
    send_request(make_req(REQ_INCREMENT, 0, '0, '0), 0);
    send_request(make_req(REQ_RESET, ALL_ENTRIES, '1, 8'hff), 2);
    send_request(make_req(REQ_INCREMENT, NUM_ENTRIES_DEF - 1, '0, '0), 0);
    // unused request code
    send_request(make_req(REQ_UNUSED, 1, '1, 8'hff), 0);
    drain_results();

    // Random traffic, in bursts and idle-heavy stretches chosen at random
    burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) burst = $urandom_range(0, 2) == 0;
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_request(random_request(), burst ? 0 : $urandom_range(0, 4));
    end
    start <= 1'b0;

    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
